[design/char_escape_codec_unit_assert.svh]
// ----------------------------------------------------------------------------
// char_escape_codec_unit_assert.svh
// assertion macros for the escape codec, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef CHAR_ESCAPE_CODEC_UNIT_ASSERT_SVH
`define CHAR_ESCAPE_CODEC_UNIT_ASSERT_SVH

// same-cycle implication
`define CEC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cec assertion failed");

// next-cycle implication
`define CEC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cec assertion failed");

`endif

[design/cec_pkg.sv]
// ----------------------------------------------------------------------------
// cec_pkg
// types and constants of the identifier escape codec
// ----------------------------------------------------------------------------
package cec_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int TABLE_BYTES   = 32;
	localparam int TABLE_LIMIT   = (TABLE_ENTRIES < TABLE_BYTES) ? TABLE_ENTRIES : TABLE_BYTES;
	localparam int TBL_IDX_W     = $clog2(TABLE_BYTES);
	localparam int CNT_W         = 6;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 64;
	localparam int BYTES_PER_REG = CFG_DATA_W / 8;

	localparam logic [CNT_W-1:0] EFF_LIMIT = CNT_W'(TABLE_LIMIT);

	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CHAR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_0     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_1     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_2     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_3     = 3'd5;

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	localparam logic [7:0] ESCAPE_RESET  = 8'h5f;
	localparam logic [7:0] ASCII_ZERO    = 8'h30;
	localparam logic [7:0] ASCII_NINE    = 8'h39;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
	localparam logic [7:0] DIGIT_MAX     = 8'd9;
	localparam logic [7:0] LETTER_BASE   = 8'd10;

	typedef struct packed {
		logic       command;
		logic [7:0] char_in;
		logic       name_last;
	} in_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       run_last;
		logic       name_end;
		logic       bad_escape;
	} out_t;

endpackage

[design/char_escape_codec_unit.sv]
// ----------------------------------------------------------------------------
// char_escape_codec_unit
// escape encoder/decoder for identifier bytes with a configurable special table
// ----------------------------------------------------------------------------
// item_s1 holds the accepted item; its results are registered in out_q
// throughput: one item per cycle when it yields one result and out_q is free;
//   one yielding two is held until both pass the single-byte output register
// reset: arst_n clears handshake state, escape-pending flag and config
//   registers (escape byte 0x5f, count and table zero)
module char_escape_codec_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cec_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output cec_pkg::out_t                 out_data,
	input  logic                          cfg_wr_en,
	input  logic [cec_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cec_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [7:0]                           esc_q;
	logic [cec_pkg::CNT_W-1:0]            count_q;
	logic [cec_pkg::TABLE_BYTES-1:0][7:0] tbl_q;

	logic          valid_s1;
	cec_pkg::in_t  item_s1;
	logic          phase_q;
	logic          pend_q;
	logic          out_valid_q;
	cec_pkg::out_t out_q;

	logic [cec_pkg::CNT_W-1:0]     eff_n;
	logic                          hit;
	logic [cec_pkg::TBL_IDX_W-1:0] hit_idx;
	logic [7:0]                    digit;
	logic                          dec_num;
	logic [cec_pkg::CNT_W-1:0]     dec_idx;
	logic                          dec_ok;
	logic [1:0]                    nres;
	cec_pkg::out_t                 res0;
	cec_pkg::out_t                 res1;
	logic                          pend_next;
	logic                          out_load;
	logic                          s1_consume;
	logic                          in_xfer;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= cec_pkg::ESCAPE_RESET;
			count_q <= '0;
			tbl_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cec_pkg::REG_ESCAPE_CHAR: begin
					esc_q <= cfg_data[7:0];
				end
				cec_pkg::REG_SPECIAL_COUNT: begin
					count_q <= cfg_data[cec_pkg::CNT_W-1:0];
				end
				cec_pkg::REG_SPECIAL_0: begin
					for (int b = 0; b < cec_pkg::BYTES_PER_REG; b++)
						tbl_q[b] <= cfg_data[b*8 +: 8];
				end
				cec_pkg::REG_SPECIAL_1: begin
					for (int b = 0; b < cec_pkg::BYTES_PER_REG; b++)
						tbl_q[cec_pkg::BYTES_PER_REG + b] <= cfg_data[b*8 +: 8];
				end
				cec_pkg::REG_SPECIAL_2: begin
					for (int b = 0; b < cec_pkg::BYTES_PER_REG; b++)
						tbl_q[2*cec_pkg::BYTES_PER_REG + b] <= cfg_data[b*8 +: 8];
				end
				cec_pkg::REG_SPECIAL_3: begin
					for (int b = 0; b < cec_pkg::BYTES_PER_REG; b++)
						tbl_q[3*cec_pkg::BYTES_PER_REG + b] <= cfg_data[b*8 +: 8];
				end
				default: begin
				end
			endcase
		end
	end

	// result generation for the held item
	always_comb begin
		eff_n = (count_q > cec_pkg::EFF_LIMIT) ? cec_pkg::EFF_LIMIT : count_q;

		// lowest matching index wins
		hit     = 1'b0;
		hit_idx = '0;
		for (int k = cec_pkg::TABLE_LIMIT - 1; k >= 0; k--) begin
			if (tbl_q[k] == item_s1.char_in && cec_pkg::CNT_W'(k) < eff_n) begin
				hit     = 1'b1;
				hit_idx = cec_pkg::TBL_IDX_W'(k);
			end
		end
		if (8'(hit_idx) <= cec_pkg::DIGIT_MAX)
			digit = cec_pkg::ASCII_ZERO + 8'(hit_idx);
		else
			digit = cec_pkg::ASCII_LOWER_A + 8'(hit_idx) - cec_pkg::LETTER_BASE;

		dec_num = 1'b0;
		dec_idx = '0;
		if (item_s1.char_in >= cec_pkg::ASCII_ZERO && item_s1.char_in <= cec_pkg::ASCII_NINE) begin
			dec_num = 1'b1;
			dec_idx = cec_pkg::CNT_W'(item_s1.char_in - cec_pkg::ASCII_ZERO);
		end else if (item_s1.char_in >= cec_pkg::ASCII_LOWER_A
				&& item_s1.char_in <= cec_pkg::ASCII_LOWER_Z) begin
			dec_num = 1'b1;
			dec_idx = cec_pkg::CNT_W'(item_s1.char_in - cec_pkg::ASCII_LOWER_A
				+ cec_pkg::LETTER_BASE);
		end
		dec_ok = dec_num && (dec_idx < eff_n);

		nres      = 2'd1;
		pend_next = 1'b0;
		res0      = '{char_out: item_s1.char_in, run_last: 1'b1,
			name_end: item_s1.name_last, bad_escape: 1'b0};
		res1      = res0;

		if (item_s1.command == cec_pkg::CMD_ENCODE) begin
			if (item_s1.char_in == esc_q || hit) begin
				nres = 2'd2;
				res0 = '{char_out: esc_q, run_last: 1'b0, name_end: 1'b0, bad_escape: 1'b0};
				res1 = '{char_out: (item_s1.char_in == esc_q) ? esc_q : digit,
					run_last: 1'b1, name_end: item_s1.name_last, bad_escape: 1'b0};
			end
		end else if (!pend_q) begin
			if (item_s1.char_in == esc_q) begin
				if (item_s1.name_last) begin
					res0 = '{char_out: 8'd0, run_last: 1'b1, name_end: 1'b1, bad_escape: 1'b1};
				end else begin
					nres      = 2'd0;
					pend_next = 1'b1;
				end
			end
		end else if (item_s1.char_in == esc_q) begin
			res0.char_out = esc_q;
		end else if (dec_ok) begin
			res0.char_out = tbl_q[dec_idx[cec_pkg::TBL_IDX_W-1:0]];
		end else begin
			res0.char_out   = 8'd0;
			res0.bad_escape = 1'b1;
		end
	end

	assign out_load   = !out_valid_q || out_ready;
	assign s1_consume = valid_s1 && (nres == 2'd0
		|| (out_load && (nres == 2'd1 || phase_q)));
	assign in_ready   = !valid_s1 || s1_consume;
	assign in_xfer    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer)
				valid_s1 <= 1'b1;
			else if (s1_consume)
				valid_s1 <= 1'b0;
			if (s1_consume)
				phase_q <= 1'b0;
			else if (valid_s1 && out_load && nres == 2'd2)
				phase_q <= 1'b1;
			if (s1_consume)
				pend_q <= pend_next;
			if (out_load)
				out_valid_q <= valid_s1 && nres != 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			item_s1 <= in_data;
		if (out_load)
			out_q <= phase_q ? res1 : res0;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`include "char_escape_codec_unit_assert.svh"

	`CEC_ASSERT_NOW(a_phase_needs_item, phase_q, valid_s1)
	`CEC_ASSERT_NOW(a_bad_is_zero_last, out_valid_q && out_q.bad_escape,
		out_q.char_out == 8'd0 && out_q.run_last)
	`CEC_ASSERT_NOW(a_first_not_end, out_valid_q && !out_q.run_last, !out_q.name_end)
	`CEC_ASSERT_NEXT(a_pend_from_decode, s1_consume && item_s1.command == cec_pkg::CMD_ENCODE,
		!pend_q)

endmodule

[sim/cec_check_pkg.sv]
// ----------------------------------------------------------------------------
// cec_check_pkg
// scoreboard for the escape codec: mirrors the config registers and the
// escape-pending flag, predicts the output bytes of every accepted input and
// checks each output transfer field by field against the oldest prediction
// ----------------------------------------------------------------------------
package cec_check_pkg;

	import cec_pkg::*;

	function automatic logic [7:0] index_char(int k);
		if (k <= int'(DIGIT_MAX))
			return ASCII_ZERO + 8'(k);
		return ASCII_LOWER_A + 8'(k - int'(LETTER_BASE));
	endfunction

	class codec_scoreboard;
		logic [7:0]  esc;
		logic [5:0]  count;
		logic [63:0] spec_regs [4];
		bit          pending;
		out_t        expected_bytes [$];
		int          errors;

		function new();
			esc = ESCAPE_RESET;
			count = '0;
			foreach (spec_regs[i]) spec_regs[i] = '0;
			pending = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ESCAPE_CHAR:   esc = data[7:0];
				REG_SPECIAL_COUNT: count = data[CNT_W-1:0];
				REG_SPECIAL_0:     spec_regs[0] = data;
				REG_SPECIAL_1:     spec_regs[1] = data;
				REG_SPECIAL_2:     spec_regs[2] = data;
				REG_SPECIAL_3:     spec_regs[3] = data;
				default: ;
			endcase
		endfunction

		function int active_entries();
			int n;
			n = int'(count);
			if (n > TABLE_LIMIT) n = TABLE_LIMIT;
			return n;
		endfunction

		function logic [7:0] entry(int k);
			return spec_regs[(k >> 3) & 3][(k & 7) * 8 +: 8];
		endfunction

		function void push_byte(logic [7:0] ch, logic last, logic nend, logic bad);
			out_t w;
			w.char_out = ch;
			w.run_last = last;
			w.name_end = nend;
			w.bad_escape = bad;
			expected_bytes.insert(expected_bytes.size(), w);
		endfunction

		function void note_input(in_t it);
			int n;
			int idx;
			n = active_entries();
			if (it.command == CMD_ENCODE) begin
				pending = 1'b0;
				if (it.char_in == esc) begin
					push_byte(esc, 1'b0, 1'b0, 1'b0);
					push_byte(esc, 1'b1, it.name_last, 1'b0);
					return;
				end
				for (int k = 0; k < n; k++) begin
					if (entry(k) == it.char_in) begin
						push_byte(esc, 1'b0, 1'b0, 1'b0);
						push_byte(index_char(k), 1'b1, it.name_last, 1'b0);
						return;
					end
				end
				push_byte(it.char_in, 1'b1, it.name_last, 1'b0);
				return;
			end
			if (!pending) begin
				if (it.char_in == esc) begin
					if (it.name_last)
						push_byte(8'h00, 1'b1, 1'b1, 1'b1);
					else
						pending = 1'b1;
					return;
				end
				push_byte(it.char_in, 1'b1, it.name_last, 1'b0);
				return;
			end
			pending = 1'b0;
			if (it.char_in == esc) begin
				push_byte(esc, 1'b1, it.name_last, 1'b0);
				return;
			end
			idx = 64;
			if (it.char_in >= ASCII_ZERO && it.char_in <= ASCII_NINE)
				idx = int'(it.char_in - ASCII_ZERO);
			else if (it.char_in >= ASCII_LOWER_A && it.char_in <= ASCII_LOWER_Z)
				idx = int'(it.char_in - ASCII_LOWER_A) + int'(LETTER_BASE);
			if (idx < n)
				push_byte(entry(idx), 1'b1, it.name_last, 1'b0);
			else
				push_byte(8'h00, 1'b1, it.name_last, 1'b1);
		endfunction

		task report(string msg);
			$display("tb: mismatch: %s", msg);
			errors++;
		endtask

		task check_result(out_t got);
			out_t want;
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected output transfer %h", got));
				return;
			end
			want = expected_bytes.pop_front();
			if (got.char_out !== want.char_out)
				report($sformatf("char_out %h, want %h", got.char_out, want.char_out));
			if (got.run_last !== want.run_last)
				report($sformatf("run_last %b, want %b", got.run_last, want.run_last));
			if (got.name_end !== want.name_end)
				report($sformatf("name_end %b, want %b", got.name_end, want.name_end));
			if (got.bad_escape !== want.bad_escape)
				report($sformatf("bad_escape %b, want %b", got.bad_escape, want.bad_escape));
		endtask
	endclass

endpackage

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives directed and random name streams through the escape codec in both
// directions under several table settings, with random gaps and output stalls,
// and checks every output transfer against the scoreboard's prediction
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import cec_pkg::*;
	import cec_check_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_t                   in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_t                  out_data;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	codec_scoreboard sb;
	int              items_sent = 0;
	bit              tx_calm = 1'b0;
	int              rx_stall = 0;
	bit              rx_calm = 1'b0;
	int              rx_ticks = 0;
	int unsigned     cycles = 0;

	char_escape_codec_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// output side: check each transfer, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
		rx_ticks++;
		if (rx_ticks % 300 == 0)
			rx_calm = ($urandom_range(0, 3) == 0);
		if (rx_stall > 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
			rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic int tx_gap();
		int r;
		if (tx_calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic send(logic cmd, logic [7:0] ch, logic last);
		int gap;
		in_t it;
		it.command = cmd;
		it.char_in = ch;
		it.name_last = last;
		gap = tx_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_bytes.size() != 0);
	endtask

	// escape starts leave no result, so give the pipeline time to settle
	task automatic wait_idle();
		wait_drained();
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	function automatic logic [7:0] name_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) return sb.esc;
		if (r < 6) return sb.entry($urandom_range(0, 31));
		return 8'($urandom);
	endfunction

	function automatic logic [63:0] table_word(int style);
		logic [63:0] w;
		w = {$urandom, $urandom};
		if (style == 1)
			for (int b = 0; b < 8; b++) w[b * 8 +: 8] = 8'h2a + 8'($urandom_range(0, 5));
		return w;
	endfunction

	task automatic encode_name();
		int len;
		len = $urandom_range(1, 8);
		for (int i = 0; i < len; i++) send(CMD_ENCODE, name_byte(), i == len - 1);
	endtask

	// mostly well-formed escaped names, some with broken escapes
	task automatic decode_name(bit broken);
		int len;
		int kind;
		int n;
		int k;
		logic [7:0] b;
		logic last;
		len = $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			last = (i == len - 1);
			kind = $urandom_range(0, 9);
			if (broken && $urandom_range(0, 2) == 0) kind = 10;
			if (kind < 4) begin
				b = 8'($urandom);
				if (b == sb.esc) b = ~b;
				send(CMD_DECODE, b, last);
			end else if (kind < 6) begin
				send(CMD_DECODE, sb.esc, 1'b0);
				send(CMD_DECODE, sb.esc, last);
			end else if (kind < 10) begin
				n = sb.active_entries();
				k = (n > 0 && $urandom_range(0, 5) != 0) ? $urandom_range(0, n - 1)
					: $urandom_range(0, 35);
				send(CMD_DECODE, sb.esc, 1'b0);
				send(CMD_DECODE, index_char(k), last);
			end else begin
				case ($urandom_range(0, 2))
					0: send(CMD_DECODE, sb.esc, last);
					1: begin
						send(CMD_DECODE, sb.esc, 1'b0);
						send(CMD_DECODE, 8'($urandom), last);
					end
					default: begin
						send(CMD_DECODE, sb.esc, 1'b0);
						send(CMD_ENCODE, name_byte(), last);
					end
				endcase
			end
		end
	endtask

	task automatic run_random(int count);
		int start;
		int r;
		bit paused;
		start = items_sent;
		paused = 1'b0;
		while (items_sent - start < count) begin
			if (!paused && items_sent - start >= count / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			tx_calm = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 35)
				encode_name();
			else if (r < 80)
				decode_name(r >= 72);
			else
				repeat ($urandom_range(1, 6))
					send(logic'($urandom_range(0, 1)), 8'($urandom), logic'($urandom_range(0, 1)));
		end
	endtask

	task automatic configure(int phase);
		logic [7:0]  esc_v;
		logic [5:0]  cnt;
		int          style;
		logic [63:0] words [4];
		case (phase)
			1: begin esc_v = 8'h00; cnt = 6'd32; style = 0; end
			2: begin esc_v = 8'hff; cnt = 6'd63; style = 1; end
			3: begin esc_v = 8'($urandom); cnt = 6'd0; style = 0; end
			4: begin esc_v = ESCAPE_RESET; cnt = 6'd10; style = 0; end
			5: begin esc_v = 8'($urandom); cnt = 6'($urandom_range(0, 63)); style = 1; end
			6: begin esc_v = 8'($urandom); cnt = 6'd33; style = 0; end
			default: begin
				esc_v = 8'($urandom);
				cnt = 6'($urandom_range(0, 32));
				style = $urandom_range(0, 1);
			end
		endcase
		foreach (words[i]) words[i] = table_word(style);
		if ($urandom_range(0, 1) == 1)
			words[$urandom_range(0, 3)][$urandom_range(0, 7) * 8 +: 8] = esc_v;
		write_reg(REG_ESCAPE_CHAR, {56'd0, esc_v});
		write_reg(REG_SPECIAL_COUNT, {58'd0, cnt});
		write_reg(REG_SPECIAL_0, words[0]);
		write_reg(REG_SPECIAL_1, words[1]);
		write_reg(REG_SPECIAL_2, words[2]);
		write_reg(REG_SPECIAL_3, words[3]);
		if (phase == 6) begin
			write_reg(REG_UNUSED_6, {$urandom, $urandom});
			write_reg(REG_UNUSED_7, {$urandom, $urandom});
		end
	endtask

	task automatic run_directed();
		// entries: . / - _ $ sp 00 ff # . @ + then unused ~
		write_reg(REG_ESCAPE_CHAR, {56'd0, ESCAPE_RESET});
		write_reg(REG_SPECIAL_COUNT, 64'd12);
		write_reg(REG_SPECIAL_0, 64'hff00_2024_5f2d_2f2e);
		write_reg(REG_SPECIAL_1, 64'h7e7e_7e7e_2b40_2e23);
		write_reg(REG_SPECIAL_2, {$urandom, $urandom});
		write_reg(REG_SPECIAL_3, {$urandom, $urandom});
		send(CMD_ENCODE, "A", 1'b0);
		send(CMD_ENCODE, ESCAPE_RESET, 1'b0);
		send(CMD_ENCODE, ".", 1'b0);
		send(CMD_ENCODE, "+", 1'b0);
		send(CMD_ENCODE, "@", 1'b0);
		send(CMD_ENCODE, "~", 1'b0);
		send(CMD_ENCODE, 8'h00, 1'b0);
		send(CMD_ENCODE, 8'hff, 1'b1);
		send(CMD_DECODE, "A", 1'b0);
		send(CMD_DECODE, 8'hff, 1'b0);
		send(CMD_DECODE, ESCAPE_RESET, 1'b0);
		send(CMD_DECODE, ESCAPE_RESET, 1'b0);
		send(CMD_DECODE, ESCAPE_RESET, 1'b0);
		send(CMD_DECODE, "3", 1'b0);
		send(CMD_DECODE, ESCAPE_RESET, 1'b0);
		send(CMD_DECODE, "b", 1'b0);
		send(CMD_DECODE, ESCAPE_RESET, 1'b0);
		send(CMD_DECODE, "c", 1'b0);
		send(CMD_DECODE, ESCAPE_RESET, 1'b0);
		send(CMD_DECODE, 8'hff, 1'b0);
		send(CMD_DECODE, ESCAPE_RESET, 1'b1);
		send(CMD_DECODE, ESCAPE_RESET, 1'b0);
		send(CMD_ENCODE, "x", 1'b1);
		send(CMD_DECODE, "9", 1'b1);
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_random(120);
		wait_idle();
		run_directed();
		for (int phase = 1; phase <= 7; phase++) begin
			wait_idle();
			configure(phase);
			run_random(250);
		end
		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.expected_bytes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/cec_pkg.sv
design/char_escape_codec_unit.sv
sim/cec_check_pkg.sv
sim/testbench.sv
